### rtl/tribary_pkg.sv
// Shared types and constants for the barycentric point-in-triangle block.
package tribary_pkg;

  // Field widths.
  localparam int COORD_W = 12;
  localparam int FRAC_W  = 16;
  localparam int BARY_W  = 24;
  localparam int MAP_W   = 28;

  // Internal arithmetic widths.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 2;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int NUM_W   = MAG_W + FRAC_W;
  localparam int MPROD_W = DIFF_W + BARY_W;
  localparam int SUM_W   = MPROD_W + 2;

  // Quotient carries one bit beyond the result so that overflow is visible.
  localparam int QUO_W      = BARY_W + 1;
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd5;

  // Operation codes.
  localparam logic OP_TO_BARY = 1'b0;
  localparam logic OP_TO_POINT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tribary_cfg_t;

  // Per-item state carried through the divider stages.
  typedef struct packed {
    logic                     op;
    logic                     degen;
    logic                     in_tri;
    logic                     neg_u;
    logic                     neg_v;
    logic                     ovf_u;
    logic                     ovf_v;
    logic [MAG_W-1:0]         den;
    logic [MAG_W-1:0]         rem_u;
    logic [MAG_W-1:0]         rem_v;
    logic [QUO_W-1:0]         nbits_u;
    logic [QUO_W-1:0]         nbits_v;
    logic [QUO_W-1:0]         quo_u;
    logic [QUO_W-1:0]         quo_v;
    logic signed [MAP_W-1:0]  map_x;
    logic signed [MAP_W-1:0]  map_y;
    logic                     map_sat;
  } tribary_div_t;

endpackage

### rtl/tribary_front.sv
// Front pipeline: edge vectors, cross products, sign fixup, mapped sums and divider setup.
module tribary_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    adv_i,
  input  logic                                    valid_i,
  input  logic                                    op_i,
  input  logic signed [tribary_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [tribary_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [tribary_pkg::BARY_W-1:0]   coord_u_i,
  input  logic signed [tribary_pkg::BARY_W-1:0]   coord_v_i,
  input  tribary_pkg::tribary_cfg_t               cfg_i,
  output logic                                    valid_o,
  output tribary_pkg::tribary_div_t               div_o
);
  import tribary_pkg::*;

  localparam logic signed [SUM_W-1:0] MAP_HI = SUM_W'((64'sd1 <<< (MAP_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] MAP_LO = -MAP_HI - SUM_W'(1);

  // Stage 1: differences against vertex a.
  logic                      v1_q;
  logic                      op1_q;
  logic signed [DIFF_W-1:0]  dx_q, dy_q, e0x_q, e0y_q, e1x_q, e1y_q;
  logic signed [BARY_W-1:0]  u1_q, w1_q;
  logic signed [COORD_W-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q <= op_i;
      dx_q  <= DIFF_W'(point_x_i) - DIFF_W'(cfg_i.ax);
      dy_q  <= DIFF_W'(point_y_i) - DIFF_W'(cfg_i.ay);
      e0x_q <= DIFF_W'(cfg_i.cx) - DIFF_W'(cfg_i.ax);
      e0y_q <= DIFF_W'(cfg_i.cy) - DIFF_W'(cfg_i.ay);
      e1x_q <= DIFF_W'(cfg_i.bx) - DIFF_W'(cfg_i.ax);
      e1y_q <= DIFF_W'(cfg_i.by) - DIFF_W'(cfg_i.ay);
      u1_q  <= coord_u_i;
      w1_q  <= coord_v_i;
      ax1_q <= cfg_i.ax;
      ay1_q <= cfg_i.ay;
    end
  end

  // Stage 2: all products, registered.
  logic                       v2_q;
  logic                       op2_q;
  logic signed [PROD_W-1:0]   p_dxe1y_q, p_dye1x_q, p_e0xdy_q, p_e0ydx_q;
  logic signed [PROD_W-1:0]   p_e0xe1y_q, p_e0ye1x_q;
  logic signed [MPROD_W-1:0]  m_e0xu_q, m_e1xv_q, m_e0yu_q, m_e1yv_q;
  logic signed [SUM_W-1:0]    a_x_sh_q, a_y_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op2_q      <= op1_q;
      p_dxe1y_q  <= PROD_W'(dx_q) * PROD_W'(e1y_q);
      p_dye1x_q  <= PROD_W'(dy_q) * PROD_W'(e1x_q);
      p_e0xdy_q  <= PROD_W'(e0x_q) * PROD_W'(dy_q);
      p_e0ydx_q  <= PROD_W'(e0y_q) * PROD_W'(dx_q);
      p_e0xe1y_q <= PROD_W'(e0x_q) * PROD_W'(e1y_q);
      p_e0ye1x_q <= PROD_W'(e0y_q) * PROD_W'(e1x_q);
      m_e0xu_q   <= MPROD_W'(e0x_q) * MPROD_W'(u1_q);
      m_e1xv_q   <= MPROD_W'(e1x_q) * MPROD_W'(w1_q);
      m_e0yu_q   <= MPROD_W'(e0y_q) * MPROD_W'(u1_q);
      m_e1yv_q   <= MPROD_W'(e1y_q) * MPROD_W'(w1_q);
      a_x_sh_q   <= SUM_W'(ax1_q) <<< FRAC_W;
      a_y_sh_q   <= SUM_W'(ay1_q) <<< FRAC_W;
    end
  end

  // Stage 3: cross products, made positive in the denominator, and mapped sums.
  logic signed [CROSS_W-1:0] nu_c, nv_c, den_c;
  logic                      v3_q;
  logic                      op3_q;
  logic signed [CROSS_W-1:0] nu_q, nv_q, den_q;
  logic signed [SUM_W-1:0]   mx_q, my_q;

  always_comb begin
    nu_c  = CROSS_W'(p_dxe1y_q) - CROSS_W'(p_dye1x_q);
    nv_c  = CROSS_W'(p_e0xdy_q) - CROSS_W'(p_e0ydx_q);
    den_c = CROSS_W'(p_e0xe1y_q) - CROSS_W'(p_e0ye1x_q);
    if (den_c < 0) begin
      nu_c  = -nu_c;
      nv_c  = -nv_c;
      den_c = -den_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op3_q <= op2_q;
      nu_q  <= nu_c;
      nv_q  <= nv_c;
      den_q <= den_c;
      mx_q  <= a_x_sh_q + SUM_W'(m_e0xu_q) + SUM_W'(m_e1xv_q);
      my_q  <= a_y_sh_q + SUM_W'(m_e0yu_q) + SUM_W'(m_e1yv_q);
    end
  end

  // Stage 4: inside test, magnitudes, divider seed, overflow check, map clamp.
  tribary_div_t              div_d;
  logic [CROSS_W-1:0]        abs_u, abs_v;
  logic [NUM_W-1:0]          num_u, num_v;
  logic [MAG_W-1:0]          seed_u, seed_v;
  logic signed [CROSS_W:0]   sum_uv;
  logic                      v4_q;
  tribary_div_t              div_q;

  always_comb begin
    abs_u  = (nu_q < 0) ? CROSS_W'(-nu_q) : CROSS_W'(nu_q);
    abs_v  = (nv_q < 0) ? CROSS_W'(-nv_q) : CROSS_W'(nv_q);
    num_u  = {abs_u[MAG_W-1:0], {FRAC_W{1'b0}}};
    num_v  = {abs_v[MAG_W-1:0], {FRAC_W{1'b0}}};
    seed_u = MAG_W'(num_u >> QUO_W);
    seed_v = MAG_W'(num_v >> QUO_W);
    sum_uv = (CROSS_W+1)'(nu_q) + (CROSS_W+1)'(nv_q);

    div_d.op      = op3_q;
    div_d.den     = den_q[MAG_W-1:0];
    div_d.degen   = (den_q == '0);
    div_d.in_tri  = (nu_q > 0) && (nv_q > 0) && (sum_uv < (CROSS_W+1)'(den_q));
    div_d.neg_u   = (nu_q < 0);
    div_d.neg_v   = (nv_q < 0);
    div_d.ovf_u   = (seed_u >= den_q[MAG_W-1:0]);
    div_d.ovf_v   = (seed_v >= den_q[MAG_W-1:0]);
    div_d.rem_u   = seed_u;
    div_d.rem_v   = seed_v;
    div_d.nbits_u = num_u[QUO_W-1:0];
    div_d.nbits_v = num_v[QUO_W-1:0];
    div_d.quo_u   = '0;
    div_d.quo_v   = '0;
    div_d.map_sat = 1'b0;

    if (mx_q > MAP_HI) begin
      div_d.map_x   = MAP_W'(MAP_HI);
      div_d.map_sat = 1'b1;
    end else if (mx_q < MAP_LO) begin
      div_d.map_x   = MAP_W'(MAP_LO);
      div_d.map_sat = 1'b1;
    end else begin
      div_d.map_x   = MAP_W'(mx_q);
    end

    if (my_q > MAP_HI) begin
      div_d.map_y   = MAP_W'(MAP_HI);
      div_d.map_sat = 1'b1;
    end else if (my_q < MAP_LO) begin
      div_d.map_y   = MAP_W'(MAP_LO);
      div_d.map_sat = 1'b1;
    end else begin
      div_d.map_y   = MAP_W'(my_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = v4_q;
  assign div_o   = div_q;

endmodule

### rtl/tribary_div.sv
// One divider stage: DIV_STEPS restoring division steps for both u and v.
module tribary_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  tribary_pkg::tribary_div_t  div_i,
  output logic                       valid_o,
  output tribary_pkg::tribary_div_t  div_o
);
  import tribary_pkg::*;

  tribary_div_t      div_d;
  tribary_div_t      div_q;
  logic              valid_q;
  logic [MAG_W:0]    trial_u, trial_v;

  // Each step shifts in the next dividend bit and subtracts when it fits.
  always_comb begin
    div_d   = div_i;
    trial_u = '0;
    trial_v = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial_u = {div_d.rem_u, div_d.nbits_u[QUO_W-1]};
      trial_v = {div_d.rem_v, div_d.nbits_v[QUO_W-1]};
      div_d.nbits_u = {div_d.nbits_u[QUO_W-2:0], 1'b0};
      div_d.nbits_v = {div_d.nbits_v[QUO_W-2:0], 1'b0};
      if (trial_u >= {1'b0, div_d.den}) begin
        div_d.rem_u = MAG_W'(trial_u - {1'b0, div_d.den});
        div_d.quo_u = {div_d.quo_u[QUO_W-2:0], 1'b1};
      end else begin
        div_d.rem_u = MAG_W'(trial_u);
        div_d.quo_u = {div_d.quo_u[QUO_W-2:0], 1'b0};
      end
      if (trial_v >= {1'b0, div_d.den}) begin
        div_d.rem_v = MAG_W'(trial_v - {1'b0, div_d.den});
        div_d.quo_v = {div_d.quo_v[QUO_W-2:0], 1'b1};
      end else begin
        div_d.rem_v = MAG_W'(trial_v);
        div_d.quo_v = {div_d.quo_v[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

### rtl/triangle_barycentric_test_top.sv
// Path from an input transfer to its result on the output register: four front stages,
// five divider stages and the output register.
// Throughput: one item per cycle; the front stages and five divider stages each
// take a new item every cycle, and the whole pipeline holds while the output stalls.
// Reset clears all valid bits and sets every vertex register to zero.
// Top level of the barycentric point-in-triangle block.
module triangle_barycentric_test_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tribary_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tribary_pkg::COORD_W-1:0]        cfg_data_i,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x[11:0], point_y[23:12], coord_u[47:24], coord_v[71:48]
  input  logic [71:0]                            s_axis_tdata,
  // operation[0]
  input  logic                                   s_axis_tuser,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // inside_res[0], degenerate[1], bary_u[25:2], bary_v[49:26], mapped_x[77:50],
  // mapped_y[105:78], saturated[106], zero fill[111:107]
  output logic [111:0]                           m_axis_tdata
);
  import tribary_pkg::*;

  localparam logic [QUO_W-1:0] BARY_POS_MAX = QUO_W'((1 << (BARY_W - 1)) - 1);
  localparam logic [QUO_W-1:0] BARY_NEG_MAX = QUO_W'(1 << (BARY_W - 1));

  // Vertex registers.
  tribary_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AX:  cfg_q.ax <= cfg_data_i;
        REG_AY:  cfg_q.ay <= cfg_data_i;
        REG_BX:  cfg_q.bx <= cfg_data_i;
        REG_BY:  cfg_q.by <= cfg_data_i;
        REG_CX:  cfg_q.cx <= cfg_data_i;
        REG_CY:  cfg_q.cy <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // The pipeline moves whenever the output register is free or being emptied.
  logic adv;
  logic out_valid_q;

  assign adv           = m_axis_tready || !out_valid_q;
  assign s_axis_tready = adv;

  // Front stages.
  logic         front_valid;
  tribary_div_t front_div;

  tribary_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .point_x_i (s_axis_tdata[11:0]),
    .point_y_i (s_axis_tdata[23:12]),
    .coord_u_i (s_axis_tdata[47:24]),
    .coord_v_i (s_axis_tdata[71:48]),
    .cfg_i     (cfg_q),
    .valid_o   (front_valid),
    .div_o     (front_div)
  );

  // Divider stages.
  logic         dv_valid [DIV_STAGES+1];
  tribary_div_t dv_div   [DIV_STAGES+1];

  assign dv_valid[0] = front_valid;
  assign dv_div[0]   = front_div;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tribary_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_valid[g]),
      .div_i   (dv_div[g]),
      .valid_o (dv_valid[g+1]),
      .div_o   (dv_div[g+1])
    );
  end

  // Final signs, saturation and result selection.
  tribary_div_t             fin;
  logic                     sat_u, sat_v;
  logic signed [BARY_W-1:0] res_u, res_v;
  logic [111:0]             out_data_d;
  logic [111:0]             out_data_q;

  always_comb begin
    fin = dv_div[DIV_STAGES];

    if (fin.neg_u) begin
      sat_u = fin.ovf_u || (fin.quo_u > BARY_NEG_MAX);
      res_u = sat_u ? BARY_W'(-BARY_NEG_MAX) : BARY_W'(-fin.quo_u);
    end else begin
      sat_u = fin.ovf_u || (fin.quo_u > BARY_POS_MAX);
      res_u = sat_u ? BARY_W'(BARY_POS_MAX) : BARY_W'(fin.quo_u);
    end
    if (fin.neg_v) begin
      sat_v = fin.ovf_v || (fin.quo_v > BARY_NEG_MAX);
      res_v = sat_v ? BARY_W'(-BARY_NEG_MAX) : BARY_W'(-fin.quo_v);
    end else begin
      sat_v = fin.ovf_v || (fin.quo_v > BARY_POS_MAX);
      res_v = sat_v ? BARY_W'(BARY_POS_MAX) : BARY_W'(fin.quo_v);
    end

    out_data_d = '0;
    if (fin.op == OP_TO_POINT) begin
      out_data_d[77:50]  = fin.map_x;
      out_data_d[105:78] = fin.map_y;
      out_data_d[106]    = fin.map_sat;
    end else if (fin.degen) begin
      out_data_d[1] = 1'b1;
    end else begin
      out_data_d[0]     = fin.in_tri;
      out_data_d[25:2]  = res_u;
      out_data_d[49:26] = res_v;
      out_data_d[106]   = sat_u || sat_v;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
